@@ rtl/dvsbp_pkg.sv @@
// Package for the event camera byte stream parser.
// Holds register indexes, timestamp mode codes and the shared structs.
// No dependencies.
package dvsbp_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_ADDRESS_MODE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMESTAMP_MODE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ONLINE_MODE    = 2'd2;

    localparam logic [2:0] TS_NONE  = 3'd0;
    localparam logic [2:0] TS_TWO   = 3'd1;
    localparam logic [2:0] TS_THREE = 3'd2;
    localparam logic [2:0] TS_FOUR  = 3'd3;
    localparam logic [2:0] TS_DELTA = 3'd4;

    localparam logic [3:0] ADDR_BYTES_SHORT = 4'd2;
    localparam logic [3:0] ADDR_BYTES_LONG  = 4'd4;
    localparam logic [3:0] DELTA_MAX_BYTES  = 4'd4;

    localparam logic [31:0] WRAP_TWO   = 32'h0001_0000;
    localparam logic [31:0] WRAP_THREE = 32'h0100_0000;

    typedef struct packed {
        logic       address_mode;
        logic [2:0] timestamp_mode;
        logic       online_mode;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        logic [6:0]  x;
        logic [6:0]  y;
        logic [31:0] timestamp;
    } event_t;

endpackage

@@ rtl/dvsbp_frame.sv @@
// Frame assembly: byte count, address and timestamp shift registers,
// timestamp unwrap and delta accumulation. Produces one event per frame.
// Depends on dvsbp_pkg.
module dvsbp_frame
    import dvsbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  logic [7:0] step_byte,
    input  cfg_t       cfg,
    input  logic       cfg_clear,
    output event_t     evt
);

    logic [3:0]  count_reg, count_next;
    logic [31:0] offset_reg, offset_next;
    logic [23:0] last_raw_reg, last_raw_next;
    logic [15:0] addr_reg, addr_next;
    logic [31:0] ts_reg, ts_next;

    logic [3:0]  alen;
    logic [3:0]  frame_len;
    logic [3:0]  count_inc;
    logic        skip;
    logic        is_addr;
    logic        ts_first;
    logic        delta;
    logic [31:0] raw_ext;
    logic        wrap;
    logic [31:0] offset_wrap;
    logic [31:0] offset_sel;
    logic [31:0] sum;
    logic        emit;
    logic [31:0] t;

    always_comb
    begin
        alen = cfg.address_mode ? ADDR_BYTES_LONG : ADDR_BYTES_SHORT;
        case (cfg.timestamp_mode)
            TS_TWO:   frame_len = alen + 4'd2;
            TS_THREE: frame_len = alen + 4'd3;
            TS_FOUR:  frame_len = alen + 4'd4;
            TS_DELTA: frame_len = alen + DELTA_MAX_BYTES;
            default:  frame_len = alen;
        endcase

        delta     = (cfg.timestamp_mode == TS_DELTA);
        skip      = cfg.online_mode && (count_reg == 4'd0) && !step_byte[7];
        count_inc = count_reg + 4'd1;
        is_addr   = (count_reg < alen);
        ts_first  = (count_reg == alen);

        addr_next = is_addr ? {addr_reg[7:0], step_byte} : addr_reg;

        if (is_addr)
            ts_next = ts_reg;
        else if (delta)
            ts_next = ts_first ? {25'd0, step_byte[6:0]} : {ts_reg[24:0], step_byte[6:0]};
        else
            ts_next = ts_first ? {24'd0, step_byte} : {ts_reg[23:0], step_byte};

        case (cfg.timestamp_mode)
            TS_TWO:   raw_ext = {16'd0, ts_next[15:0]};
            TS_THREE: raw_ext = {8'd0, ts_next[23:0]};
            default:  raw_ext = ts_next;
        endcase

        wrap = ((cfg.timestamp_mode == TS_TWO) || (cfg.timestamp_mode == TS_THREE))
               && (raw_ext[23:0] < last_raw_reg);
        offset_wrap = offset_reg
                      + ((cfg.timestamp_mode == TS_TWO) ? WRAP_TWO : WRAP_THREE);
        offset_sel  = wrap ? offset_wrap : offset_reg;
        sum         = raw_ext + offset_sel;

        if (delta)
            emit = (count_inc > alen) && step_byte[7];
        else
            emit = (count_inc >= frame_len);

        count_next    = count_reg;
        offset_next   = offset_reg;
        last_raw_next = last_raw_reg;
        t             = 32'd0;

        if (!skip)
        begin
            if (emit)
            begin
                count_next = 4'd0;
                case (cfg.timestamp_mode)
                    TS_TWO, TS_THREE:
                    begin
                        offset_next   = offset_sel;
                        last_raw_next = raw_ext[23:0];
                        t             = sum;
                    end
                    TS_FOUR:
                    begin
                        last_raw_next = ts_next[23:0];
                        t             = ts_next;
                    end
                    TS_DELTA:
                    begin
                        offset_next   = sum;
                        last_raw_next = sum[23:0];
                        t             = sum;
                    end
                    TS_NONE:
                    begin
                        last_raw_next = 24'd0;
                    end
                    default:
                    begin
                        last_raw_next = 24'd0;
                    end
                endcase
            end
            else if (delta && (count_inc > alen) && (count_inc >= alen + DELTA_MAX_BYTES))
                count_next = 4'd0;
            else
                count_next = count_inc;
        end

        evt.valid     = step_en && !skip && emit;
        evt.timestamp = t;
        if (cfg.online_mode)
        begin
            evt.x = addr_next[6:0];
            evt.y = ~addr_next[14:8];
        end
        else
        begin
            evt.x = addr_next[7:1];
            evt.y = addr_next[14:8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= 4'd0;
            offset_reg   <= 32'd0;
            last_raw_reg <= 24'd0;
        end
        else if (cfg_clear)
        begin
            count_reg    <= 4'd0;
            offset_reg   <= 32'd0;
            last_raw_reg <= 24'd0;
        end
        else if (step_en)
        begin
            count_reg    <= count_next;
            offset_reg   <= offset_next;
            last_raw_reg <= last_raw_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en && !skip)
        begin
            addr_reg <= addr_next;
            ts_reg   <= ts_next;
        end
    end

endmodule

@@ rtl/dvs_event_byte_parser_core.sv @@
// A byte is held in the input register; its event (if any) then in the result register.
// Throughput: one byte per cycle while the output is not stalled.
// The input register stalls only when a result is held and the output is stalled.
// Reset (async, rst_n low): config registers, frame count, time offset and last raw
// time clear to zero; input and result registers go empty.
// Top level of the event camera byte stream parser. Depends on dvsbp_pkg, dvsbp_frame.
module dvs_event_byte_parser_core
    import dvsbp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             data_byte,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [6:0]             x,
    output logic [6:0]             y,
    output logic [31:0]            timestamp
);

    cfg_t        cfg_reg;
    logic        cfg_clear;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    logic [6:0]  x_reg;
    logic [6:0]  y_reg;
    logic [31:0] timestamp_reg;
    logic        step_en;
    logic        in_take;
    event_t      evt;

    assign step_en   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !step_en;
    assign in_take   = in_valid && !in_stall;
    assign cfg_clear = cfg_write_en
                       && ((cfg_index == REG_ADDRESS_MODE) || (cfg_index == REG_TIMESTAMP_MODE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_ADDRESS_MODE:   cfg_reg.address_mode   <= cfg_data[0];
                REG_TIMESTAMP_MODE: cfg_reg.timestamp_mode <= cfg_data;
                REG_ONLINE_MODE:    cfg_reg.online_mode    <= cfg_data[0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (step_en)
                in_valid_reg <= 1'b0;

            if (step_en)
                out_valid_reg <= evt.valid;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_byte_reg <= data_byte;
        if (evt.valid)
        begin
            x_reg         <= evt.x;
            y_reg         <= evt.y;
            timestamp_reg <= evt.timestamp;
        end
    end

    dvsbp_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .step_byte (in_byte_reg),
        .cfg       (cfg_reg),
        .cfg_clear (cfg_clear),
        .evt       (evt)
    );

    assign out_valid = out_valid_reg;
    assign x         = x_reg;
    assign y         = y_reg;
    assign timestamp = timestamp_reg;

endmodule
